@@ rtl/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the stable sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef enum logic [0:0] {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } t_command;

    typedef enum logic [1:0] {
        ST_INSERTED  = 2'd0,
        ST_REMOVED   = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_OVERFLOW  = 2'd3
    } t_status;

    typedef struct packed {
        t_command           command;
        logic signed [31:0] item_value;
        logic signed [15:0] item_priority;
    } t_in_item;

    typedef struct packed {
        t_status            status;
        logic signed [31:0] out_value;
        logic signed [15:0] out_priority;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic execute;
    } t_dp_cmd;

endpackage

@@ rtl/stable_priority_queue.sv @@
// ----------------------------------------------------------------------------
// stable_priority_queue
// Sorted priority queue of CAPACITY entries; equal priorities leave in
// arrival order. Top level joining the controller and the datapath.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Handshake               | Payload
//  in       | input     | i_in_valid / o_in_ready | i_in_item  (t_in_item)
//  out      | output    | o_out_valid / i_out_ready | o_out_item (t_out_item)
//
// Each command is first captured from the transfer; then the compare-and-shift
// array updates all slots in parallel and the result register is loaded.
// A new command is accepted while an earlier result still waits; execution
// holds only while the result register is occupied and not being drained.
// Synchronous active-low reset empties the queue; no clearing pass is needed.
// ----------------------------------------------------------------------------
module stable_priority_queue
    import spq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    t_dp_cmd w_cmd;

    spq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    spq_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_in_item  (i_in_item),
        .o_out_item (o_out_item)
    );

endmodule

@@ rtl/spq_ctrl.sv @@
// ----------------------------------------------------------------------------
// spq_ctrl
// Controller: accepts one command, has the datapath execute it once the
// result register is free, and tracks the result handshake.
// ----------------------------------------------------------------------------
module spq_ctrl
    import spq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_res_free;

    // The result register can take a new result when empty or being drained.
    assign w_res_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state       = r_state;
        n_out_valid   = r_out_valid;
        o_cmd.capture = 1'b0;
        o_cmd.execute = 1'b0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_res_free) begin
                    o_cmd.execute = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

@@ rtl/spq_datapath.sv @@
// ----------------------------------------------------------------------------
// spq_datapath
// Compare-and-shift register array holding the sorted entries, the entry
// count, the captured command and the result register.
// ----------------------------------------------------------------------------
module spq_datapath
    import spq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_dp_cmd   i_cmd,
    input  t_in_item  i_in_item,
    output t_out_item o_out_item
);

    logic signed [31:0] r_val [CAPACITY];
    logic signed [15:0] r_pri [CAPACITY];
    logic signed [31:0] n_val [CAPACITY];
    logic signed [15:0] n_pri [CAPACITY];
    logic [CNT_W-1:0]   r_count, n_count;
    t_in_item           r_item;
    t_out_item          r_out, n_out;
    logic [CAPACITY-1:0] w_stay;
    logic               w_full, w_empty, w_write;

    assign w_full  = (r_count == CNT_W'(CAPACITY));
    assign w_empty = (r_count == '0);

    // A slot keeps its entry on insert when it is occupied and its priority
    // is not above the new one; since the array is sorted this is a prefix.
    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_slot
            assign w_stay[g] = (CNT_W'(g) < r_count) &&
                               (r_pri[g] <= r_item.item_priority);

            always_comb begin
                n_val[g] = r_val[g];
                n_pri[g] = r_pri[g];
                if (r_item.command == CMD_INSERT) begin
                    if (!w_stay[g]) begin
                        if (g == 0) begin
                            n_val[g] = r_item.item_value;
                            n_pri[g] = r_item.item_priority;
                        end else if (w_stay[(g == 0) ? 0 : g - 1]) begin
                            n_val[g] = r_item.item_value;
                            n_pri[g] = r_item.item_priority;
                        end else begin
                            n_val[g] = r_val[(g == 0) ? 0 : g - 1];
                            n_pri[g] = r_pri[(g == 0) ? 0 : g - 1];
                        end
                    end
                end else if (g < CAPACITY - 1) begin
                    n_val[g] = r_val[(g < CAPACITY - 1) ? g + 1 : g];
                    n_pri[g] = r_pri[(g < CAPACITY - 1) ? g + 1 : g];
                end
            end

            always_ff @(posedge i_clk) begin
                if (w_write) begin
                    r_val[g] <= n_val[g];
                    r_pri[g] <= n_pri[g];
                end
            end
        end
    endgenerate

    always_comb begin
        n_count = r_count;
        n_out   = '0;
        w_write = 1'b0;
        unique case (r_item.command)
            CMD_INSERT: begin
                if (w_full) begin
                    n_out.status = ST_OVERFLOW;
                end else begin
                    n_out.status = ST_INSERTED;
                    w_write      = i_cmd.execute;
                    n_count      = r_count + CNT_W'(1);
                end
            end
            CMD_REMOVE: begin
                if (w_empty) begin
                    n_out.status = ST_UNDERFLOW;
                end else begin
                    n_out.status       = ST_REMOVED;
                    n_out.out_value    = r_val[0];
                    n_out.out_priority = r_pri[0];
                    w_write            = i_cmd.execute;
                    n_count            = r_count - CNT_W'(1);
                end
            end
            default: begin
                n_out.status = ST_UNDERFLOW;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.execute) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_in_item;
        end
        if (i_cmd.execute) begin
            r_out <= n_out;
        end
    end

    assign o_out_item = r_out;

endmodule
